[design/fwb_pkg.sv]
// ----------------------------------------------------------------------------
// fwb_pkg
// shared types, constants and helpers of the fene/wca bond energy unit
// ----------------------------------------------------------------------------
package fwb_pkg;

  localparam logic [47:0] EMAX     = 48'h7FFF_FFFF_FFFF;
  localparam logic [63:0] LN2_Q32  = 64'd2977044472;
  localparam logic [63:0] ONE_Q32  = 64'h0000_0001_0000_0000;
  localparam logic [63:0] HALF_Q32 = 64'h0000_0000_8000_0000;

  localparam logic [31:0] EPS_RESET = 32'd65536;
  localparam logic [31:0] K_RESET   = 32'd1966080;
  localparam logic [31:0] R0_RESET  = 32'd98304;
  localparam logic [31:0] B_RESET   = 32'd65536;

  localparam logic [1:0] REG_WCA_EPSILON     = 2'd0;
  localparam logic [1:0] REG_SPRING_CONSTANT = 2'd1;
  localparam logic [1:0] REG_MAX_EXTENSION   = 2'd2;
  localparam logic [1:0] REG_BEAD_DIAMETER   = 2'd3;

  typedef logic [1:0] sh_t;
  localparam sh_t SH_62 = 2'd0;
  localparam sh_t SH_32 = 2'd1;
  localparam sh_t SH_25 = 2'd2;
  localparam sh_t SH_24 = 2'd3;

  typedef struct packed {
    logic [63:0] r2;
    logic        oor;
  } word_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
    sh_t         sh;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } mul_rsp_t;

  function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    logic [32:0] mag;
    d   = {b[31], b} - {a[31], a};
    mag = d[32] ? (~d + 33'd1) : d;
    return mag[31:0];
  endfunction

endpackage

[design/fwb_front.sv]
// ----------------------------------------------------------------------------
// fwb_front
// takes input words, forms the squared bond length and flags out-of-range
// ----------------------------------------------------------------------------
module fwb_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 op,
  input  logic signed [31:0]   pos_a_x,
  input  logic signed [31:0]   pos_a_y,
  input  logic signed [31:0]   pos_a_z,
  input  logic signed [31:0]   pos_b_x,
  input  logic signed [31:0]   pos_b_y,
  input  logic signed [31:0]   pos_b_z,
  input  logic        [31:0]   given_distance,
  input  logic        [63:0]   r0_sq,
  output fwb_pkg::word_t       push_word,
  output logic                 push_valid,
  input  logic                 push_ready
);

  logic        v1, v2, v3;
  logic        en1, en2, en3;
  logic [31:0] d_x, d_y, d_z;
  logic [63:0] sq_x, sq_y, sq_z;
  logic [63:0] r2_sum;
  logic        r2_over;
  logic [65:0] sum_next;

  assign en3      = !v3 || push_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  assign sum_next = {2'b00, sq_x} + {2'b00, sq_y} + {2'b00, sq_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      if (op) begin
        d_x <= given_distance;
        d_y <= 32'd0;
        d_z <= 32'd0;
      end else begin
        d_x <= fwb_pkg::abs_diff(pos_a_x, pos_b_x);
        d_y <= fwb_pkg::abs_diff(pos_a_y, pos_b_y);
        d_z <= fwb_pkg::abs_diff(pos_a_z, pos_b_z);
      end
    end
    if (en2 && v1) begin
      sq_x <= d_x * d_x;
      sq_y <= d_y * d_y;
      sq_z <= d_z * d_z;
    end
    if (en3 && v2) begin
      r2_sum  <= sum_next[63:0];
      r2_over <= |sum_next[65:64];
    end
  end

  assign push_valid    = v3;
  assign push_word.r2  = r2_sum;
  assign push_word.oor = r2_over || (r2_sum == 64'd0) || (r2_sum >= r0_sq);

endmodule

[design/fwb_fifo.sv]
// ----------------------------------------------------------------------------
// fwb_fifo
// two-entry queue of classified words between front and back
// ----------------------------------------------------------------------------
module fwb_fifo (
  input  logic           clk,
  input  logic           rst,
  input  fwb_pkg::word_t wr_word,
  input  logic           wr_valid,
  output logic           wr_ready,
  output fwb_pkg::word_t rd_word,
  output logic           rd_valid,
  input  logic           rd_ready
);

  fwb_pkg::word_t mem [2];
  logic           wr_ptr, rd_ptr;
  logic [1:0]     count;
  logic           push, pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_word  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_word;
  end

endmodule

[design/fwb_mul.sv]
// ----------------------------------------------------------------------------
// fwb_mul
// 64x64 multiply with truncating shift and saturation, one 32x32 partial
// product per cycle
// ----------------------------------------------------------------------------
module fwb_mul (
  input  logic              clk,
  input  logic              rst,
  input  fwb_pkg::mul_req_t req,
  output fwb_pkg::mul_rsp_t rsp
);

  logic [63:0]    a_q, b_q;
  fwb_pkg::sh_t   sh_q;
  logic           busy, done_q, pp_v;
  logic [2:0]     cnt;
  logic [1:0]     pp_off;
  logic [63:0]    pp;
  logic [127:0]   acc;
  logic [31:0]    op_a, op_b;
  logic [1:0]     off_next;
  logic           sat;
  logic [63:0]    val;

  always_comb begin
    case (cnt)
      3'd0: begin op_a = a_q[31:0];  op_b = b_q[31:0];  off_next = 2'd0; end
      3'd1: begin op_a = a_q[31:0];  op_b = b_q[63:32]; off_next = 2'd1; end
      3'd2: begin op_a = a_q[63:32]; op_b = b_q[31:0];  off_next = 2'd1; end
      default: begin op_a = a_q[63:32]; op_b = b_q[63:32]; off_next = 2'd2; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_q <= 1'b0;
      pp_v   <= 1'b0;
      cnt    <= 3'd0;
    end else begin
      done_q <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        pp_v <= 1'b0;
        cnt  <= 3'd0;
      end else if (busy) begin
        if (cnt != 3'd4) begin
          pp_v <= 1'b1;
          cnt  <= cnt + 3'd1;
        end else begin
          pp_v   <= 1'b0;
          busy   <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_q  <= req.a;
      b_q  <= req.b;
      sh_q <= req.sh;
      acc  <= 128'd0;
    end else begin
      if (busy && cnt != 3'd4) begin
        pp     <= op_a * op_b;
        pp_off <= off_next;
      end
      if (pp_v) begin
        case (pp_off)
          2'd0:    acc <= acc + {64'd0, pp};
          2'd1:    acc <= acc + {32'd0, pp, 32'd0};
          default: acc <= acc + {pp, 64'd0};
        endcase
      end
    end
  end

  always_comb begin
    unique case (sh_q)
      fwb_pkg::SH_62: begin sat = |acc[127:126]; val = acc[125:62]; end
      fwb_pkg::SH_32: begin sat = |acc[127:96];  val = acc[95:32];  end
      fwb_pkg::SH_25: begin sat = |acc[127:89];  val = acc[88:25];  end
      default:        begin sat = |acc[127:88];  val = acc[87:24];  end
    endcase
  end

  assign rsp.done   = done_q;
  assign rsp.result = sat ? {64{1'b1}} : val;

endmodule

[design/fwb_back.sv]
// ----------------------------------------------------------------------------
// fwb_back
// sequencer for the fene and wca terms on a shared multiplier and a
// radix-2 divider, with the output register
// ----------------------------------------------------------------------------
module fwb_back (
  input  logic                clk,
  input  logic                rst,
  input  fwb_pkg::word_t      pop_word,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  logic [31:0]         wca_epsilon,
  input  logic [31:0]         spring_constant,
  input  logic [63:0]         r0_sq,
  input  logic [63:0]         b_sq,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [47:0]  energy,
  output logic                out_of_range
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_NORM = 3'd1;
  localparam logic [2:0] ST_LOG  = 3'd2;
  localparam logic [2:0] ST_LOGW = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_MULW = 3'd5;
  localparam logic [2:0] ST_SUM  = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  localparam logic [2:0] STEP_G  = 3'd0;
  localparam logic [2:0] STEP_P  = 3'd1;
  localparam logic [2:0] STEP_E1 = 3'd2;
  localparam logic [2:0] STEP_QQ = 3'd3;
  localparam logic [2:0] STEP_S  = 3'd4;
  localparam logic [2:0] STEP_TT = 3'd5;
  localparam logic [2:0] STEP_E2 = 3'd6;

  logic [2:0]  state, step;
  logic [63:0] r2_q;
  logic        oor_q;
  logic [47:0] e_res;
  logic [63:0] x;
  logic [5:0]  shcnt;
  logic [63:0] m;
  logic [5:0]  log_int;
  logic [31:0] log_frac;
  logic [4:0]  log_k;
  logic        log_pass;
  logic [37:0] lhi, llo_next, diff;
  logic [63:0] g, p, e1, qq, tq, u, e2, q;
  logic        sq_bit;

  logic [64:0] div_rem, rem_sh;
  logic [63:0] div_dq;
  logic [6:0]  div_cnt;
  logic        q_sat, div_start, div_busy, need_div;

  logic [47:0] e1s, e2s, sum;
  logic        fin_load;

  fwb_pkg::mul_req_t mul_req;
  fwb_pkg::mul_rsp_t mul_rsp;

  fwb_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  assign pop_ready = (state == ST_IDLE);
  assign div_start = (state == ST_IDLE) && pop_valid && !pop_word.oor;
  assign div_busy  = (div_cnt != 7'd0);
  assign need_div  = (step == STEP_QQ) || (step == STEP_S) || (step == STEP_TT) ||
                     (step == STEP_E2);
  assign q         = q_sat ? {64{1'b1}} : div_dq;
  assign sq_bit    = mul_rsp.result[63];
  assign llo_next  = {log_int, log_frac[30:0], sq_bit};
  assign fin_load  = (state == ST_FIN) && (!out_valid || out_ready);

  // divider
  assign rem_sh = {div_rem[63:0], div_dq[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= 7'd0;
    end else if (div_start) begin
      div_cnt <= 7'd64;
    end else if (div_busy) begin
      div_cnt <= div_cnt - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_rem <= {33'd0, b_sq[63:32]};
      div_dq  <= {b_sq[31:0], 32'd0};
      q_sat   <= ({32'd0, b_sq[63:32]} >= pop_word.r2);
    end else if (div_busy) begin
      if (rem_sh >= {1'b0, r2_q}) begin
        div_rem <= rem_sh - {1'b0, r2_q};
        div_dq  <= {div_dq[62:0], 1'b1};
      end else begin
        div_rem <= rem_sh;
        div_dq  <= {div_dq[62:0], 1'b0};
      end
    end
  end

  // multiplier operands
  always_comb begin
    mul_req.start = 1'b0;
    mul_req.a     = 64'd0;
    mul_req.b     = 64'd0;
    mul_req.sh    = fwb_pkg::SH_32;
    if (state == ST_LOG) begin
      mul_req.start = 1'b1;
      mul_req.a     = m;
      mul_req.b     = m;
      mul_req.sh    = fwb_pkg::SH_62;
    end else begin
      mul_req.start = (state == ST_MUL) && !(need_div && div_busy);
      case (step)
        STEP_G:  begin mul_req.a = {26'd0, diff}; mul_req.b = fwb_pkg::LN2_Q32; end
        STEP_P:  begin mul_req.a = {32'd0, spring_constant}; mul_req.b = r0_sq; end
        STEP_E1: begin
          mul_req.a  = p;
          mul_req.b  = g;
          mul_req.sh = fwb_pkg::SH_25;
        end
        STEP_QQ: begin mul_req.a = q;  mul_req.b = q; end
        STEP_S:  begin mul_req.a = qq; mul_req.b = q; end
        STEP_TT: begin mul_req.a = tq; mul_req.b = tq; end
        STEP_E2: begin
          mul_req.a  = {32'd0, wca_epsilon};
          mul_req.b  = u;
          mul_req.sh = fwb_pkg::SH_24;
        end
        default: begin mul_req.a = 64'd0; mul_req.b = 64'd0; end
      endcase
    end
  end

  // final saturating sum
  assign e1s = (|e1[63:47]) ? fwb_pkg::EMAX : {1'b0, e1[46:0]};
  assign e2s = (|e2[63:47]) ? fwb_pkg::EMAX : {1'b0, e2[46:0]};
  assign sum = e1s + e2s;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= STEP_G;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            state <= pop_word.oor ? ST_FIN : ST_NORM;
          end
        end
        ST_NORM: if (x[63]) state <= ST_LOG;
        ST_LOG:  state <= ST_LOGW;
        ST_LOGW: begin
          if (mul_rsp.done) begin
            if (log_k == 5'd31) begin
              if (!log_pass) begin
                state <= ST_NORM;
              end else begin
                state <= ST_MUL;
                step  <= STEP_G;
              end
            end else begin
              state <= ST_LOG;
            end
          end
        end
        ST_MUL: if (mul_req.start) state <= ST_MULW;
        ST_MULW: begin
          if (mul_rsp.done) begin
            case (step)
              STEP_G:  begin step <= STEP_P;  state <= ST_MUL; end
              STEP_P:  begin step <= STEP_E1; state <= ST_MUL; end
              STEP_E1: begin step <= STEP_QQ; state <= ST_MUL; end
              STEP_QQ: begin step <= STEP_S;  state <= ST_MUL; end
              STEP_S: begin
                if (mul_rsp.result >= fwb_pkg::HALF_Q32) begin
                  step  <= STEP_TT;
                  state <= ST_MUL;
                end else begin
                  state <= ST_SUM;
                end
              end
              STEP_TT: begin step <= STEP_E2; state <= ST_MUL; end
              default: state <= ST_SUM;
            endcase
          end
        end
        ST_SUM: state <= ST_FIN;
        ST_FIN: if (fin_load) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (pop_valid) begin
          r2_q     <= pop_word.r2;
          oor_q    <= pop_word.oor;
          e_res    <= fwb_pkg::EMAX;
          x        <= r0_sq;
          shcnt    <= 6'd0;
          log_pass <= 1'b0;
        end
      end
      ST_NORM: begin
        if (x[63]) begin
          m        <= {1'b0, x[63:1]};
          log_int  <= ~shcnt;
          log_k    <= 5'd0;
          log_frac <= 32'd0;
        end else if (x[63:56] == 8'd0) begin
          x     <= {x[55:0], 8'd0};
          shcnt <= shcnt + 6'd8;
        end else begin
          x     <= {x[62:0], 1'b0};
          shcnt <= shcnt + 6'd1;
        end
      end
      ST_LOGW: begin
        if (mul_rsp.done) begin
          m        <= sq_bit ? {1'b0, mul_rsp.result[63:1]} : mul_rsp.result;
          log_frac <= {log_frac[30:0], sq_bit};
          log_k    <= log_k + 5'd1;
          if (log_k == 5'd31) begin
            if (!log_pass) begin
              lhi      <= llo_next;
              x        <= r0_sq - r2_q;
              shcnt    <= 6'd0;
              log_pass <= 1'b1;
            end else begin
              diff <= (lhi > llo_next) ? (lhi - llo_next) : 38'd0;
            end
          end
        end
      end
      ST_MULW: begin
        if (mul_rsp.done) begin
          case (step)
            STEP_G:  g  <= mul_rsp.result;
            STEP_P:  p  <= mul_rsp.result;
            STEP_E1: e1 <= mul_rsp.result;
            STEP_QQ: qq <= mul_rsp.result;
            STEP_S: begin
              if (mul_rsp.result >= fwb_pkg::HALF_Q32) begin
                tq <= mul_rsp.result[63] ? {64{1'b1}} :
                      ({mul_rsp.result[62:0], 1'b0} - fwb_pkg::ONE_Q32);
              end else begin
                e2 <= 64'd0;
              end
            end
            STEP_TT: u  <= mul_rsp.result;
            default: e2 <= mul_rsp.result;
          endcase
        end
      end
      ST_SUM: e_res <= sum[47] ? fwb_pkg::EMAX : sum;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      energy       <= e_res;
      out_of_range <= oor_q;
    end
  end

  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |-> (state == ST_LOGW || state == ST_MULW))
    else $error("multiplier result with no step waiting");

  a_oor_saturated: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_of_range) |-> (energy == fwb_pkg::EMAX))
    else $error("out-of-range word without saturated energy");

  a_energy_positive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !energy[47])
    else $error("negative energy");

  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    fin_load |=> (out_valid && state == ST_IDLE))
    else $error("finished word not loaded into output register");

endmodule

[design/fene_wca_bond_energy_unit.sv]
// ----------------------------------------------------------------------------
// fene_wca_bond_energy_unit
// fene bond energy with wca repulsion for one bead pair per word
//
//   port group  handshake                   payload
//   in          in_valid / in_ready         op, pos_a_*, pos_b_*, given_distance
//   out         out_valid / out_ready       energy, out_of_range
//   apb         psel, penable, pwrite       paddr, pwdata, prdata (pready high)
//
// the front is a 3-stage pipeline taking one word a cycle, while the queue has
// room, into a 2-entry queue; the back takes one word at a time, pacing an
// in-range word by the shared 32x32 multiplier running the two log2 squaring
// loops; reset is synchronous and clears control and config registers only
// (no clearing pass); in_ready drops only when front stages and queue are full
// ----------------------------------------------------------------------------
module fene_wca_bond_energy_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                op,
  input  logic signed [31:0]  pos_a_x,
  input  logic signed [31:0]  pos_a_y,
  input  logic signed [31:0]  pos_a_z,
  input  logic signed [31:0]  pos_b_x,
  input  logic signed [31:0]  pos_b_y,
  input  logic signed [31:0]  pos_b_z,
  input  logic        [31:0]  given_distance,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [47:0]  energy,
  output logic                out_of_range
);

  logic [31:0] wca_epsilon, spring_constant, max_extension, bead_diameter;
  logic [63:0] r0_sq, b_sq;
  logic        cfg_wr;

  fwb_pkg::word_t push_word, pop_word;
  logic           push_valid, push_ready, pop_valid, pop_ready;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      wca_epsilon     <= fwb_pkg::EPS_RESET;
      spring_constant <= fwb_pkg::K_RESET;
      max_extension   <= fwb_pkg::R0_RESET;
      bead_diameter   <= fwb_pkg::B_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        fwb_pkg::REG_WCA_EPSILON:     wca_epsilon     <= pwdata;
        fwb_pkg::REG_SPRING_CONSTANT: spring_constant <= pwdata;
        fwb_pkg::REG_MAX_EXTENSION:   max_extension   <= pwdata;
        default:                      bead_diameter   <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      fwb_pkg::REG_WCA_EPSILON:     prdata = wca_epsilon;
      fwb_pkg::REG_SPRING_CONSTANT: prdata = spring_constant;
      fwb_pkg::REG_MAX_EXTENSION:   prdata = max_extension;
      default:                      prdata = bead_diameter;
    endcase
  end

  always_ff @(posedge clk) begin
    r0_sq <= max_extension * max_extension;
    b_sq  <= bead_diameter * bead_diameter;
  end

  fwb_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .pos_a_x        (pos_a_x),
    .pos_a_y        (pos_a_y),
    .pos_a_z        (pos_a_z),
    .pos_b_x        (pos_b_x),
    .pos_b_y        (pos_b_y),
    .pos_b_z        (pos_b_z),
    .given_distance (given_distance),
    .r0_sq          (r0_sq),
    .push_word      (push_word),
    .push_valid     (push_valid),
    .push_ready     (push_ready)
  );

  fwb_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_word  (push_word),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .rd_word  (pop_word),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready)
  );

  fwb_back u_back (
    .clk             (clk),
    .rst             (rst),
    .pop_word        (pop_word),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .wca_epsilon     (wca_epsilon),
    .spring_constant (spring_constant),
    .r0_sq           (r0_sq),
    .b_sq            (b_sq),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .energy          (energy),
    .out_of_range    (out_of_range)
  );

endmodule
